// File: rtl/core/sac_pkg.sv
package sac_pkg;

    // Widths of the fixed fields.
    localparam int CNT_W       = 48;
    localparam int OFFSET_MAX  = 12;
    localparam int INDEX_MAX   = 10;
    localparam int RECIP_SHIFT = 20;
    localparam int TDATA_M_W   = 296;

    // Default geometry limits.
    localparam int MAX_SETS_DEF   = 1024;
    localparam int MAX_WAYS_DEF   = 16;
    localparam int ADDR_WIDTH_DEF = 64;

    // Register values after reset.
    localparam logic [3:0] OFFSET_BITS_RST = 4'd6;
    localparam logic [3:0] INDEX_BITS_RST  = 4'd5;
    localparam logic [4:0] WAYS_IN_USE_RST = 5'd4;

    // Register indexes on the configuration port.
    typedef enum logic [1:0] {
        REG_OFFSET_BITS = 2'd0,
        REG_INDEX_BITS  = 2'd1,
        REG_WAYS_IN_USE = 2'd2,
        REG_UNUSED      = 2'd3
    } cfg_reg_t;

    // Sequencer states.
    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_QUOT  = 6'b000100,
        ST_READ  = 6'b001000,
        ST_LOOK  = 6'b010000,
        ST_WRITE = 6'b100000
    } state_t;

endpackage

// File: rtl/core/sac_lookup.sv
module sac_lookup #(
    parameter int MAX_WAYS   = 16,
    parameter int ADDR_WIDTH = 64,
    parameter int WAY_W      = 4,
    parameter int WAYS_W     = 5,
    parameter int RANK_W     = 4
) (
    input  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag_row,
    input  logic [MAX_WAYS-1:0]                 valid_row,
    input  logic [MAX_WAYS-1:0][RANK_W-1:0]     rank_row,
    input  logic [ADDR_WIDTH-1:0]               tag,
    input  logic [WAYS_W-1:0]                   ways,
    output logic                                hit,
    output logic [WAY_W-1:0]                    hit_way,
    output logic [WAY_W-1:0]                    victim_way
);

    logic [RANK_W-1:0] victim_rank;

    // The highest-numbered valid matching way wins.
    always_comb begin
        hit     = 1'b0;
        hit_way = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if ((WAYS_W'(w) < ways) && valid_row[w] && (tag_row[w] == tag)) begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
        end
    end

    // Lowest rank among the ways in use, lowest way number on a tie.
    always_comb begin
        victim_way  = '0;
        victim_rank = rank_row[0];
        for (int w = 1; w < MAX_WAYS; w++) begin
            if ((WAYS_W'(w) < ways) && (rank_row[w] < victim_rank)) begin
                victim_way  = WAY_W'(w);
                victim_rank = rank_row[w];
            end
        end
    end

endmodule

// File: rtl/core/set_assoc_lru_writeback_cache_tags.sv
// Tag, state and LRU tracking for a set-associative write-back, write-allocate
// cache. Each input transaction carries a byte address in s_tdata and the write
// flag in s_tuser; each result transaction reports hit and writeback flags in
// m_tuser and the way used plus six wrapping 48-bit statistics in m_tdata.
// An access passes in order through acceptance, the set-number reduction, the
// synchronous read of the set row, the tag search and victim choice, and the
// write-back of the row, which also loads the output register. The write-back
// waits while a previous result is still held on the output. After reset the
// block clears the valid, dirty and rank row of every set, one set per cycle,
// before the first access is taken; configuration writes are accepted at any
// time.
module set_assoc_lru_writeback_cache_tags #(
    parameter int MAX_SETS   = sac_pkg::MAX_SETS_DEF,
    parameter int MAX_WAYS   = sac_pkg::MAX_WAYS_DEF,
    parameter int ADDR_WIDTH = sac_pkg::ADDR_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [63:0]                     s_tdata,   // address[63:0]
    input  logic [0:0]                      s_tuser,   // is_write[0]
    // Result stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // way_used[3:0], access_count[51:4], hit_count[99:52],
    // miss_count[147:100], writeback_count[195:148],
    // write_miss_count[243:196], write_count[291:244], zero fill[295:292]
    output logic [sac_pkg::TDATA_M_W-1:0]  m_tdata,
    output logic [1:0]                      m_tuser,   // hit[0], writeback[1]
    // Configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [3:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    import sac_pkg::*;

    localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int RANK_W = WAY_W;
    localparam int WAYS_W = $clog2(MAX_WAYS + 1);
    localparam int RECIP  = (1 << RECIP_SHIFT) / MAX_SETS;
    localparam int META_W = MAX_WAYS * (2 + RANK_W);

    // Configuration registers.
    logic [3:0] offset_bits_reg;
    logic [3:0] index_bits_reg;
    logic [4:0] ways_in_use_reg;
    cfg_reg_t   cfg_sel;
    logic       cfg_wr;

    assign pready  = 1'b1;
    assign cfg_sel = cfg_reg_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_bits_reg <= OFFSET_BITS_RST;
            index_bits_reg  <= INDEX_BITS_RST;
            ways_in_use_reg <= WAYS_IN_USE_RST;
        end else if (cfg_wr) begin
            unique case (cfg_sel)
                REG_OFFSET_BITS: offset_bits_reg <= pwdata[3:0];
                REG_INDEX_BITS:  index_bits_reg  <= pwdata[3:0];
                REG_WAYS_IN_USE: ways_in_use_reg <= pwdata[4:0];
                REG_UNUSED: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            REG_OFFSET_BITS: prdata = {28'd0, offset_bits_reg};
            REG_INDEX_BITS:  prdata = {28'd0, index_bits_reg};
            REG_WAYS_IN_USE: prdata = {27'd0, ways_in_use_reg};
            REG_UNUSED:      prdata = 32'd0;
        endcase
    end

    // Effective geometry after clamping.
    logic [3:0]        ob_eff;
    logic [3:0]        ib_eff;
    logic [WAYS_W-1:0] ways_eff;

    always_comb begin
        ob_eff = (offset_bits_reg > 4'(OFFSET_MAX)) ? 4'(OFFSET_MAX) : offset_bits_reg;
        ib_eff = (index_bits_reg > 4'(INDEX_MAX)) ? 4'(INDEX_MAX) : index_bits_reg;
        if (ways_in_use_reg == 5'd0) begin
            ways_eff = WAYS_W'(1);
        end else if (32'(ways_in_use_reg) > MAX_WAYS) begin
            ways_eff = WAYS_W'(MAX_WAYS);
        end else begin
            ways_eff = WAYS_W'(ways_in_use_reg);
        end
    end

    // Sequencer and access registers.
    state_t                  state_reg;
    logic [SET_W-1:0]        clr_cnt_reg;
    logic [INDEX_MAX-1:0]    set_raw_reg;
    logic [INDEX_MAX-1:0]    quot_reg;
    logic [SET_W-1:0]        set_reg;
    logic [ADDR_WIDTH-1:0]   tag_reg;
    logic                    wr_reg;
    logic                    commit;

    logic [ADDR_WIDTH-1:0]   addr_in;
    logic [ADDR_WIDTH-1:0]   addr_off;
    logic [INDEX_MAX-1:0]    set_raw_in;
    logic [31:0]             quot_prod;
    logic [31:0]             rem_full;
    logic [31:0]             rem_fix;
    logic [SET_W-1:0]        set_idx;

    assign s_tready = (state_reg == ST_IDLE);
    assign commit   = (state_reg == ST_WRITE) && (!m_tvalid || m_tready);

    // Field split of the incoming address.
    always_comb begin
        addr_in    = s_tdata[ADDR_WIDTH-1:0];
        addr_off   = addr_in >> ob_eff;
        set_raw_in = addr_off[INDEX_MAX-1:0] & ~({INDEX_MAX{1'b1}} << ib_eff);
    end

    // Set number modulo MAX_SETS by a reciprocal and one correction step.
    always_comb begin
        quot_prod = 32'(quot_reg) * 32'(MAX_SETS);
        rem_full  = 32'(set_raw_reg) - quot_prod;
        rem_fix   = (rem_full >= 32'(MAX_SETS)) ? (rem_full - 32'(MAX_SETS)) : rem_full;
        set_idx   = rem_fix[SET_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            unique case (state_reg)
                ST_CLEAR: begin
                    if (clr_cnt_reg == SET_W'(MAX_SETS - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= ST_QUOT;
                    end
                end
                ST_QUOT:  state_reg <= ST_READ;
                ST_READ:  state_reg <= ST_LOOK;
                ST_LOOK:  state_reg <= ST_WRITE;
                ST_WRITE: begin
                    if (commit) begin
                        state_reg <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    // Access payload captured along the way.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            set_raw_reg <= set_raw_in;
            tag_reg     <= addr_in >> (5'(ob_eff) + 5'(ib_eff));
            wr_reg      <= s_tuser[0];
        end
        if (state_reg == ST_QUOT) begin
            quot_reg <= INDEX_MAX'((42'(set_raw_reg) * 42'(RECIP)) >> RECIP_SHIFT);
        end
        if (state_reg == ST_READ) begin
            set_reg <= set_idx;
        end
    end

    // Set memories: tags, and valid, dirty and rank bits.
    logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag_mem [MAX_SETS];
    logic [META_W-1:0]                   meta_mem [MAX_SETS];

    logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag_row_reg;
    logic [META_W-1:0]                   meta_row_reg;
    logic [MAX_WAYS-1:0]                 valid_row;
    logic [MAX_WAYS-1:0]                 dirty_row;
    logic [MAX_WAYS-1:0][RANK_W-1:0]     rank_row;

    assign valid_row = meta_row_reg[MAX_WAYS-1:0];
    assign dirty_row = meta_row_reg[2*MAX_WAYS-1:MAX_WAYS];
    assign rank_row  = meta_row_reg[META_W-1:2*MAX_WAYS];

    logic [META_W-1:0] meta_clear;
    always_comb begin
        logic [MAX_WAYS-1:0][RANK_W-1:0] rk;
        for (int w = 0; w < MAX_WAYS; w++) begin
            rk[w] = RANK_W'(w);
        end
        meta_clear = {rk, {MAX_WAYS{1'b0}}, {MAX_WAYS{1'b0}}};
    end

    // Lookup over the row just read.
    logic              lk_hit;
    logic [WAY_W-1:0]  lk_hit_way;
    logic [WAY_W-1:0]  lk_victim;

    sac_lookup #(
        .MAX_WAYS   (MAX_WAYS),
        .ADDR_WIDTH (ADDR_WIDTH),
        .WAY_W      (WAY_W),
        .WAYS_W     (WAYS_W),
        .RANK_W     (RANK_W)
    ) u_lookup (
        .tag_row    (tag_row_reg),
        .valid_row  (valid_row),
        .rank_row   (rank_row),
        .tag        (tag_reg),
        .ways       (ways_eff),
        .hit        (lk_hit),
        .hit_way    (lk_hit_way),
        .victim_way (lk_victim)
    );

    logic             hit_reg;
    logic [WAY_W-1:0] way_reg;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_LOOK) begin
            hit_reg <= lk_hit;
            way_reg <= lk_hit ? lk_hit_way : lk_victim;
        end
    end

    // Row update: dirty, valid and tag of the used way, then the rank shift.
    logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag_row_new;
    logic [MAX_WAYS-1:0]                 valid_new;
    logic [MAX_WAYS-1:0]                 dirty_new;
    logic [MAX_WAYS-1:0][RANK_W-1:0]     rank_new;
    logic                                wb_now;
    logic [RANK_W-1:0]                   used_rank;

    always_comb begin
        tag_row_new = tag_row_reg;
        valid_new   = valid_row;
        dirty_new   = dirty_row;
        rank_new    = rank_row;
        used_rank   = rank_row[way_reg];
        wb_now      = !hit_reg && dirty_row[way_reg];
        if (hit_reg) begin
            if (wr_reg) begin
                dirty_new[way_reg] = 1'b1;
            end
        end else begin
            tag_row_new[way_reg] = tag_reg;
            valid_new[way_reg]   = 1'b1;
            dirty_new[way_reg]   = wr_reg;
        end
        for (int w = 0; w < MAX_WAYS; w++) begin
            if ((WAYS_W'(w) < ways_eff) && (rank_row[w] > used_rank)) begin
                rank_new[w] = rank_row[w] - 1'b1;
            end
        end
        rank_new[way_reg] = RANK_W'(ways_eff - 1'b1);
    end

    // Memory read and write ports.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_CLEAR) begin
            meta_mem[clr_cnt_reg] <= meta_clear;
        end else if (commit) begin
            meta_mem[set_reg] <= {rank_new, dirty_new, valid_new};
        end
        if (state_reg == ST_READ) begin
            meta_row_reg <= meta_mem[set_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (commit && !hit_reg) begin
            tag_mem[set_reg] <= tag_row_new;
        end
        if (state_reg == ST_READ) begin
            tag_row_reg <= tag_mem[set_idx];
        end
    end

    // Statistics counters.
    logic [CNT_W-1:0] acc_cnt_reg, hit_cnt_reg, miss_cnt_reg;
    logic [CNT_W-1:0] wb_cnt_reg, wmiss_cnt_reg, wr_cnt_reg;
    logic [CNT_W-1:0] acc_next, hit_next, miss_next, wb_next, wmiss_next, wr_next;

    always_comb begin
        acc_next   = acc_cnt_reg + 1'b1;
        hit_next   = hit_cnt_reg + CNT_W'(hit_reg);
        miss_next  = miss_cnt_reg + CNT_W'(!hit_reg);
        wb_next    = wb_cnt_reg + CNT_W'(wb_now);
        wmiss_next = wmiss_cnt_reg + CNT_W'(!hit_reg && wr_reg);
        wr_next    = wr_cnt_reg + CNT_W'(wr_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_cnt_reg   <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            wb_cnt_reg    <= '0;
            wmiss_cnt_reg <= '0;
            wr_cnt_reg    <= '0;
        end else if (commit) begin
            acc_cnt_reg   <= acc_next;
            hit_cnt_reg   <= hit_next;
            miss_cnt_reg  <= miss_next;
            wb_cnt_reg    <= wb_next;
            wmiss_cnt_reg <= wmiss_next;
            wr_cnt_reg    <= wr_next;
        end
    end

    // Output register.
    logic                  m_tvalid_reg;
    logic [TDATA_M_W-1:0]  m_tdata_reg;
    logic [1:0]            m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (commit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_tdata_reg <= {4'd0, wr_next, wmiss_next, wb_next, miss_next, hit_next,
                            acc_next, 4'(way_reg)};
            m_tuser_reg <= {wb_now, hit_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Checks.
    a_accept_to_quot: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_QUOT))
        else $error("accepted access did not start the set reduction");

    a_count_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (hit_cnt_reg + miss_cnt_reg) == acc_cnt_reg)
        else $error("hit and miss counts do not add up to access count");

    a_acc_step: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> (acc_cnt_reg == $past(acc_cnt_reg) + 1'b1))
        else $error("access count did not advance on a result");

    a_hit_no_wb: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("writeback reported on a hit");

endmodule

// File: dv/cache_tag_checker.sv
`timescale 1ns / 100ps

// Watches both streams, keeps a copy of the cache tag state and compares
// every result transaction with the predicted one.
module cache_tag_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [63:0]  s_tdata,
    input  logic [0:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [295:0] m_tdata,
    input  logic [1:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output int           fail_count,
    output int           pending,
    output int           hit_total,
    output int           wb_total
);
    import sac_pkg::*;

    localparam int NSETS = 1024;
    localparam int NWAYS = 16;

    typedef struct packed {
        logic [1:0]   flags;
        logic [295:0] payload;
    } access_result_t;

    logic [63:0] line_tag [NSETS*NWAYS];
    logic        line_valid [NSETS*NWAYS];
    logic        line_dirty [NSETS*NWAYS];
    logic [3:0]  line_rank [NSETS*NWAYS];
    logic [47:0] stats [6];
    logic [3:0]  cur_offset;
    logic [3:0]  cur_index;
    logic [4:0]  cur_ways;

    access_result_t expected_results [$];

    // Works out the result of one access and updates the shadow state.
    function automatic access_result_t predict_access(logic [63:0] addr, logic wr);
        int ob, ib, ways, base, used, used_rank;
        logic [63:0] set_no, tag;
        logic hit, wb;
        access_result_t r;
        ob = (cur_offset > 12) ? 12 : cur_offset;
        ib = (cur_index > 10) ? 10 : cur_index;
        ways = (cur_ways < 1) ? 1 : (cur_ways > NWAYS) ? NWAYS : cur_ways;
        set_no = ((addr >> ob) & ((64'd1 << ib) - 1)) % NSETS;
        tag = addr >> (ob + ib);
        base = int'(set_no) * NWAYS;
        hit = 0;
        wb = 0;
        used = 0;
        stats[0]++;
        if (wr) stats[5]++;
        for (int w = 0; w < ways; w++) begin
            if (line_valid[base+w] && line_tag[base+w] == tag) begin
                hit = 1;
                used = w;
            end
        end
        if (hit) begin
            stats[1]++;
            if (wr) line_dirty[base+used] = 1;
        end else begin
            stats[2]++;
            if (wr) stats[4]++;
            used = 0;
            for (int w = 1; w < ways; w++)
                if (line_rank[base+w] < line_rank[base+used]) used = w;
            if (line_dirty[base+used]) begin
                wb = 1;
                stats[3]++;
            end
            line_tag[base+used] = tag;
            line_valid[base+used] = 1;
            line_dirty[base+used] = wr;
        end
        used_rank = line_rank[base+used];
        for (int w = 0; w < ways; w++)
            if (line_rank[base+w] > used_rank) line_rank[base+w]--;
        line_rank[base+used] = 4'(ways - 1);
        r.flags = {wb, hit};
        r.payload = {4'd0, stats[5], stats[4], stats[3], stats[2], stats[1],
                     stats[0], 4'(used)};
        return r;
    endfunction

    assign pending = expected_results.size();

    // Shadow state, register writes, prediction and comparison.
    always @(posedge aclk) begin
        access_result_t exp_r;
        if (!aresetn) begin
            for (int e = 0; e < NSETS*NWAYS; e++) begin
                line_tag[e] = '0;
                line_valid[e] = 0;
                line_dirty[e] = 0;
                line_rank[e] = 4'(e % NWAYS);
            end
            for (int k = 0; k < 6; k++) stats[k] = '0;
            cur_offset = OFFSET_BITS_RST;
            cur_index = INDEX_BITS_RST;
            cur_ways = WAYS_IN_USE_RST;
            fail_count = 0;
            hit_total = 0;
            wb_total = 0;
            expected_results.delete();
        end else begin
            if (psel && penable && pwrite) begin
                case (paddr[3:2])
                    REG_OFFSET_BITS: cur_offset = pwdata[3:0];
                    REG_INDEX_BITS:  cur_index = pwdata[3:0];
                    REG_WAYS_IN_USE: cur_ways = pwdata[4:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result transaction %h", $time, m_tdata);
                    fail_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (m_tuser !== exp_r.flags || m_tdata !== exp_r.payload) begin
                        $display("%0t: mismatch expected flags %b data %h", $time,
                                 exp_r.flags, exp_r.payload);
                        $display("%0t:          actual   flags %b data %h", $time,
                                 m_tuser, m_tdata);
                        fail_count++;
                    end
                    if (m_tuser[0]) hit_total++;
                    if (m_tuser[1]) wb_total++;
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_access(s_tdata, s_tuser[0]));
        end
    end
endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import sac_pkg::*;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [63:0]  s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [295:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         psel = 0;
    logic         penable = 0;
    logic         pwrite = 0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    int           fail_count, pending, hit_total, wb_total;
    int           idle_cycles = 0;
    int           sent = 0;
    logic [63:0]  hot_tags [8];

    always #10 aclk = ~aclk;

    set_assoc_lru_writeback_cache_tags uut (.*);

    cache_tag_checker checker_i (.*);

    // Receiver stalls on its own pattern, with calm stretches.
    always @(posedge aclk) begin
        int phase;
        phase = int'(($time / 20) % 400);
        m_tready <= (phase < 80) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_reg(cfg_reg_t r, logic [31:0] v);
        @(posedge aclk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {r, 2'b00}; pwdata <= v;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // Drains all results, then lets the pipeline settle before reconfiguring.
    task automatic drain_and_configure(logic [3:0] ob, logic [3:0] ib, logic [4:0] w);
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        write_reg(REG_OFFSET_BITS, 32'(ob));
        write_reg(REG_INDEX_BITS, 32'(ib));
        write_reg(REG_WAYS_IN_USE, 32'(w));
    endtask

    // Sends one access transaction and waits for it to be accepted.
    task automatic send_access(logic [63:0] addr, logic wr);
        s_tvalid <= 1;
        s_tdata <= addr;
        s_tuser <= wr;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
    endtask

    task automatic pause_sender();
        s_tvalid <= 0;
        repeat ($urandom_range(1, 8)) @(posedge aclk);
    endtask

    // Random burst: mostly reuse of a small tag pool to get hits and evictions.
    task automatic random_phase(int n);
        int burst;
        logic [63:0] a;
        burst = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) < 8)
                a = hot_tags[$urandom_range(0, 7)] ^ 64'($urandom_range(0, 4095));
            else
                a = {$urandom, $urandom};
            send_access(a, 1'($urandom_range(0, 1)));
            if (--burst == 0) begin
                pause_sender();
                burst = $urandom_range(1, 12);
            end
        end
        s_tvalid <= 0;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        for (int k = 0; k < 8; k++)
            hot_tags[k] = {$urandom, $urandom} & ~64'hFFF;
        hot_tags[0] = '1 & ~64'hFFF;
        hot_tags[1] = '0;

        // Directed: address extremes, conflicts in one set, all-ones tag.
        send_access(64'h0, 1'b0);
        send_access(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_access(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        for (int k = 0; k < 6; k++) send_access(64'(k) << 11, 1'b1);
        send_access(64'h0, 1'b1);
        send_access(64'hAAAA_5555_AAAA_5555, 1'b0);
        send_access(64'h5555_AAAA_5555_AAAA, 1'b1);
        s_tvalid <= 0;

        // Out-of-range settings: offset and index clamp, zero ways acts as one.
        drain_and_configure(4'd15, 4'd15, 5'd0);
        send_access(64'h0, 1'b1);
        send_access(64'h1000_0000, 1'b1);
        send_access(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_access(64'h0, 1'b0);
        s_tvalid <= 0;
        drain_and_configure(4'd0, 4'd0, 5'd31);
        send_access(64'h0, 1'b1);
        send_access(64'h1, 1'b0);
        send_access(64'h1, 1'b1);
        s_tvalid <= 0;

        // Random phases over several geometries, no state cleared between them.
        drain_and_configure(4'd6, 4'd5, 5'd4);
        random_phase(150);
        drain_and_configure(4'd12, 4'd10, 5'd16);
        random_phase(150);
        drain_and_configure(4'd0, 4'd2, 5'd1);
        random_phase(150);
        drain_and_configure(4'd13, 4'd0, 5'd17);
        random_phase(150);
        drain_and_configure(4'd4, 4'd3, 5'd2);
        random_phase(130);

        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("Sent %0d accesses over seven register settings;", sent);
        $display("observed %0d hits and %0d writebacks.", hit_total, wb_total);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// File: files.f
rtl/core/sac_pkg.sv
rtl/core/sac_lookup.sv
rtl/core/set_assoc_lru_writeback_cache_tags.sv
dv/cache_tag_checker.sv
dv/tb_top.sv
